### hdl/wrmse_pkg.sv
// ============================================================================
// wrmse_pkg: shared types, constants and ROM builder for the weighted RGB
// mean-squared-error accumulator.
// ============================================================================
`default_nettype none

package wrmse_pkg;

	// Field and datapath widths
	localparam int FIELD_W     = 12;
	localparam int WIDE_W      = 16;
	localparam int WEIGHT_W    = 16;
	localparam int WEIGHT_FRAC = 14;
	localparam int MAG_W       = WIDE_W + WEIGHT_W;
	localparam int ERR_W       = MAG_W - WEIGHT_FRAC;
	localparam int SQ_W        = 2 * ERR_W;
	localparam int LANES       = 3;
	localparam int ADD_W       = SQ_W + 2;
	localparam int ACC_W       = 64;
	localparam int MEAN_W      = 40;
	localparam int OUT_CNT_W   = 32;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int S_DATA_W    = 2 * LANES * FIELD_W;
	localparam int M_DATA_W    = 80;
	localparam int M_PAD_W     = M_DATA_W - MEAN_W - OUT_CNT_W - 1;

	// Lane pipeline depth: ROM read, diff, weight, shift, square
	localparam int LANE_LAT = 5;

	// Rounding term for the floor toward minus infinity on negative diffs
	localparam logic [MAG_W:0] ROUND_ADD = (MAG_W + 1)'((1 << WEIGHT_FRAC) - 1);

	// Reset weight: 1.0 in Q2.14
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << WEIGHT_FRAC);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAMMA        = 2'd0,
		CFG_WEIGHT_RED   = 2'd1,
		CFG_WEIGHT_GREEN = 2'd2,
		CFG_WEIGHT_BLUE  = 2'd3
	} cfg_idx_t;

	// Sideband that travels beside the lane pipeline
	typedef struct packed {
		logic valid;
		logic last;
	} beat_ctl_t;

	// Request from the accumulator to the divider
	typedef struct packed {
		logic start;
		logic sat;
	} div_req_t;

	// Elaboration-time helpers for the sRGB table
	// Shift-subtract long division, 128 by 64 bits
	function automatic logic [127:0] udiv128(input logic [127:0] num, input logic [63:0] den);
		logic [64:0]  rem;
		logic [127:0] quo;
		rem = '0;
		quo = '0;
		for (int k = 127; k >= 0; k--) begin
			rem = {rem[63:0], num[k]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[k] = 1'b1;
			end
		end
		return quo;
	endfunction

	// (a * b) >> 62 for Q62 operands
	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	function automatic logic [63:0] pow12_q62(input logic [63:0] u);
		logic [63:0] u2;
		logic [63:0] u4;
		logic [63:0] u8;
		u2 = mul_q62(u, u);
		u4 = mul_q62(u2, u2);
		u8 = mul_q62(u4, u4);
		return mul_q62(u8, u4);
	endfunction

	// One entry of round(65535 * srgb_encode(idx / max))
	function automatic logic [WIDE_W-1:0] srgb_entry(input logic [63:0] idx, input int chan_bits);
		logic [63:0]  maxv;
		logic [63:0]  x;
		logic [63:0]  lo;
		logic [63:0]  hi;
		logic [63:0]  mid;
		logic [63:0]  u2;
		logic [63:0]  u4;
		logic [63:0]  t32;
		logic [63:0]  num;
		logic [63:0]  sub;
		logic [127:0] xq;
		logic [127:0] y;
		maxv = (64'd1 << chan_bits) - 64'd1;
		if (idx * 64'd10000000 <= 64'd31308 * maxv) begin
			// linear segment
			y = udiv128(128'(64'd84671220 * idx + 64'd50 * maxv), 64'd100 * maxv);
		end else begin
			// power segment: x^(1/12) by bisection, then fifth power
			xq = udiv128({64'd0, idx} << 62, maxv);
			x  = xq[63:0];
			lo = 64'd0;
			hi = 64'd1 << 62;
			for (int k = 0; k < 68; k++) begin
				if (lo < hi) begin
					mid = lo + ((hi - lo + 64'd1) >> 1);
					if (pow12_q62(mid) <= x)
						lo = mid;
					else
						hi = mid - 64'd1;
				end
			end
			u2  = mul_q62(lo, lo);
			u4  = mul_q62(u2, u2);
			t32 = mul_q62(u4, lo) >> 30;
			num = 64'd69139425 * t32;
			sub = 64'd3604425 << 32;
			if (num <= sub)
				y = '0;
			else
				y = udiv128(128'(num - sub + (64'd500 << 32)), 64'd1000 << 32);
		end
		if (y > 128'd65535)
			return '1;
		return y[WIDE_W-1:0];
	endfunction

endpackage

`default_nettype wire

### hdl/wrmse_lane.sv
// ============================================================================
// wrmse_lane: one color channel lane
// Widens source and reconstructed values (sRGB ROM or bit replication),
// forms the weighted difference and squares it. Five stages.
// ============================================================================
`default_nettype none

module wrmse_lane #(
	parameter int CHANNEL_BITS = 12
) (
	input  logic                             clk,
	input  logic                             gamma_metric,
	input  logic [wrmse_pkg::WEIGHT_W-1:0]   weight,
	input  logic [CHANNEL_BITS-1:0]          src,
	input  logic [CHANNEL_BITS-1:0]          rec,
	output logic [wrmse_pkg::SQ_W-1:0]       sq
);
	import wrmse_pkg::*;

	localparam int ROM_DEPTH = 1 << CHANNEL_BITS;
	localparam int REP_W     = WIDE_W - CHANNEL_BITS;

	logic [WIDE_W-1:0] rom_mem [ROM_DEPTH];
	logic [WIDE_W-1:0] rom_src_s1, rom_rec_s1;
	logic [WIDE_W-1:0] rep_src_s1, rep_rec_s1;
	logic [WIDE_W-1:0] wide_src, wide_rec;
	logic [WIDE_W-1:0] absd_s2;
	logic              neg_s2;
	logic [MAG_W-1:0]  mag_s3;
	logic              neg_s3;
	logic [MAG_W:0]    mag_rnd;
	logic [ERR_W-1:0]  err_s4;
	logic [SQ_W-1:0]   sq_s5;

	// sRGB encode table, built at elaboration
	for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
		localparam logic [WIDE_W-1:0] ENTRY = srgb_entry(64'(g), CHANNEL_BITS);
		assign rom_mem[g] = ENTRY;
	end

	// s1: table read, bit replication
	always_ff @(posedge clk) begin
		rom_src_s1 <= rom_mem[src];
		rom_rec_s1 <= rom_mem[rec];
		rep_src_s1 <= {src, src[CHANNEL_BITS-1 -: REP_W]};
		rep_rec_s1 <= {rec, rec[CHANNEL_BITS-1 -: REP_W]};
	end

	assign wide_src = gamma_metric ? rom_src_s1 : rep_src_s1;
	assign wide_rec = gamma_metric ? rom_rec_s1 : rep_rec_s1;

	// s2: magnitude and sign of the difference
	always_ff @(posedge clk) begin
		neg_s2  <= wide_src < wide_rec;
		absd_s2 <= (wide_src < wide_rec) ? wide_rec - wide_src : wide_src - wide_rec;
	end

	// s3: weight
	always_ff @(posedge clk) begin
		neg_s3 <= neg_s2;
		mag_s3 <= MAG_W'(absd_s2) * MAG_W'(weight);
	end

	// s4: divide by 16384, floor toward minus infinity
	assign mag_rnd = {1'b0, mag_s3} + ROUND_ADD;

	always_ff @(posedge clk) begin
		if (neg_s3)
			err_s4 <= ERR_W'(mag_rnd >> WEIGHT_FRAC);
		else
			err_s4 <= ERR_W'(mag_s3 >> WEIGHT_FRAC);
	end

	// s5: square
	always_ff @(posedge clk) begin
		sq_s5 <= SQ_W'(err_s4) * SQ_W'(err_s4);
	end

	assign sq = sq_s5;

endmodule

`default_nettype wire

### hdl/wrmse_merge.sv
// ============================================================================
// wrmse_merge: lane merge and image accumulator
// Adds the lane squares, accumulates into a saturating sum, counts pixels,
// and on a last beat hands the totals to the divider and clears.
// ============================================================================
`default_nettype none

module wrmse_merge #(
	parameter int COUNT_BITS = 32
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  wrmse_pkg::beat_ctl_t                              ctl,
	input  logic [wrmse_pkg::LANES-1:0][wrmse_pkg::SQ_W-1:0]  sq,
	output wrmse_pkg::div_req_t                               req,
	output logic [wrmse_pkg::ACC_W-1:0]                       req_sum,
	output logic [COUNT_BITS-1:0]                             req_cnt
);
	import wrmse_pkg::*;

	beat_ctl_t          ctl_s6;
	logic [ADD_W-1:0]   add_sum;
	logic [ADD_W-1:0]   add_s6;
	logic [ACC_W-1:0]   sum_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic               sat_q;
	logic [ACC_W:0]     sum_ext;
	logic [ACC_W-1:0]   sum_nxt;
	logic [COUNT_BITS-1:0] cnt_nxt;
	logic               cnt_full;
	logic               sat_nxt;
	div_req_t           req_q;
	logic [ACC_W-1:0]   req_sum_q;
	logic [COUNT_BITS-1:0] req_cnt_q;

	// lane adder tree
	always_comb begin
		add_sum = '0;
		for (int l = 0; l < LANES; l++)
			add_sum = add_sum + ADD_W'(sq[l]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_s6 <= '0;
		else
			ctl_s6 <= ctl;
	end

	always_ff @(posedge clk) begin
		add_s6 <= add_sum;
	end

	// saturating update of sum and count
	assign sum_ext  = {1'b0, sum_q} + (ACC_W + 1)'(add_s6);
	assign sum_nxt  = sum_ext[ACC_W] ? '1 : sum_ext[ACC_W-1:0];
	assign cnt_full = &cnt_q;
	assign cnt_nxt  = cnt_full ? cnt_q : cnt_q + 1'b1;
	assign sat_nxt  = sat_q | sum_ext[ACC_W] | cnt_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			sat_q <= 1'b0;
			req_q <= '0;
		end else begin
			req_q.start <= ctl_s6.valid & ctl_s6.last;
			req_q.sat   <= sat_nxt;
			if (ctl_s6.valid) begin
				if (ctl_s6.last) begin
					sum_q <= '0;
					cnt_q <= '0;
					sat_q <= 1'b0;
				end else begin
					sum_q <= sum_nxt;
					cnt_q <= cnt_nxt;
					sat_q <= sat_nxt;
				end
			end
		end
	end

	// totals of the closing image
	always_ff @(posedge clk) begin
		req_sum_q <= sum_nxt;
		req_cnt_q <= cnt_nxt;
	end

	assign req     = req_q;
	assign req_sum = req_sum_q;
	assign req_cnt = req_cnt_q;

endmodule

`default_nettype wire

### hdl/wrmse_div.sv
// ============================================================================
// wrmse_div: mean divider and result register
// Restoring division of the 64-bit sum by the pixel count, one quotient bit
// per cycle, then holds the result beat until it is taken.
// ============================================================================
`default_nettype none

module wrmse_div #(
	parameter int COUNT_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wrmse_pkg::div_req_t           req,
	input  logic [wrmse_pkg::ACC_W-1:0]   req_sum,
	input  logic [COUNT_BITS-1:0]         req_cnt,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [wrmse_pkg::MEAN_W-1:0]  mean,
	output logic [COUNT_BITS-1:0]         count,
	output logic                          sat
);
	import wrmse_pkg::*;

	localparam int STEP_W = $clog2(ACC_W);

	typedef enum logic [2:0] {
		DIV_IDLE = 3'b001,
		DIV_RUN  = 3'b010,
		DIV_DONE = 3'b100
	} div_state_t;

	div_state_t            state_q;
	logic [STEP_W-1:0]     step_q;
	logic [ACC_W-1:0]      quo_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [COUNT_BITS-1:0] dvs_q;
	logic                  sat_q;
	logic [COUNT_BITS:0]   trial;
	logic                  fits;
	logic [COUNT_BITS:0]   trial_sub;

	// one restoring step
	assign trial     = {rem_q, quo_q[ACC_W-1]};
	assign fits      = trial >= {1'b0, dvs_q};
	assign trial_sub = trial - {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				DIV_IDLE: begin
					if (req.start) begin
						state_q <= DIV_RUN;
						step_q  <= STEP_W'(ACC_W - 1);
					end
				end
				DIV_RUN: begin
					step_q <= step_q - 1'b1;
					if (step_q == '0)
						state_q <= DIV_DONE;
				end
				DIV_DONE: begin
					if (res_ready)
						state_q <= DIV_IDLE;
				end
				default: state_q <= DIV_IDLE;
			endcase
		end
	end

	// dividend shifts out as the quotient shifts in
	always_ff @(posedge clk) begin
		if (state_q == DIV_IDLE && req.start) begin
			quo_q <= req_sum;
			rem_q <= '0;
			dvs_q <= req_cnt;
			sat_q <= req.sat;
		end else if (state_q == DIV_RUN) begin
			quo_q <= {quo_q[ACC_W-2:0], fits};
			rem_q <= fits ? trial_sub[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
		end
	end

	// clamp to the output width; empty count reads as zero
	always_comb begin
		if (dvs_q == '0)
			mean = '0;
		else if (|quo_q[ACC_W-1:MEAN_W])
			mean = '1;
		else
			mean = quo_q[MEAN_W-1:0];
	end

	assign res_valid = (state_q == DIV_DONE);
	assign count     = dvs_q;
	assign sat       = sat_q;

endmodule

`default_nettype wire

### hdl/weighted_rgb_mse_accumulator.sv
// ============================================================================
// weighted_rgb_mse_accumulator: weighted RGB MSE over an image
// Three channel lanes, a merging accumulator and a serial mean divider.
// ============================================================================
//
// Input stream (s_*): one pixel pair per beat, tlast marks the last pixel of
// an image. Output stream (m_*): one result beat per image carrying the
// floored mean of the weighted squared error, the pixel count and a sticky
// saturation flag.
// Throughput: one pixel beat per cycle inside an image. After a tlast beat
// s_tready stays low until the result beat has been taken.
// Path: after the tlast beat the result passes five lane stages (table read,
// difference, weight multiply, shift, square), one lane sum, one accumulate
// stage, then the one-bit-per-cycle divider, which sets the gap between
// images.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 gamma
// select, 1..3 red/green/blue weights); write only while the block is idle.
// Reset: clears sum, count, flag and all control; weights return to 1.0 and
// the gamma select to off. A stalled result beat is held in place with its
// data stable; the input side stays stalled meanwhile.
//
`default_nettype none

module weighted_rgb_mse_accumulator #(
	parameter int CHANNEL_BITS = 12,
	parameter int COUNT_BITS   = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// pixel stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// src_red, src_green, src_blue, rec_red, rec_green, rec_blue (12 bits each)
	input  logic [wrmse_pkg::S_DATA_W-1:0]    s_tdata,
	input  logic                              s_tlast,
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// mean_error (40), pixels_seen (32), saturated (1), zero pad (7)
	output logic [wrmse_pkg::M_DATA_W-1:0]    m_tdata,
	// configuration
	input  logic                              cfg_we,
	input  logic [wrmse_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wrmse_pkg::CFG_W-1:0]       cfg_data
);
	import wrmse_pkg::*;

	logic                              gamma_q;
	logic [LANES-1:0][WEIGHT_W-1:0]    weight_q;
	logic                              busy_q;
	logic                              s_beat;
	beat_ctl_t                         ctl_pipe_q [LANE_LAT];
	logic [LANES-1:0][SQ_W-1:0]        lane_sq;
	div_req_t                          req;
	logic [ACC_W-1:0]                  req_sum;
	logic [COUNT_BITS-1:0]             req_cnt;
	logic [MEAN_W-1:0]                 mean;
	logic [COUNT_BITS-1:0]             count;
	logic                              sat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q  <= 1'b0;
			weight_q <= {LANES{WEIGHT_ONE}};
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_GAMMA:        gamma_q     <= cfg_data[0];
				CFG_WEIGHT_RED:   weight_q[0] <= cfg_data;
				CFG_WEIGHT_GREEN: weight_q[1] <= cfg_data;
				CFG_WEIGHT_BLUE:  weight_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// one image in flight past its last beat at a time
	assign s_tready = !busy_q;
	assign s_beat   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= 1'b0;
		else if (s_beat && s_tlast)
			busy_q <= 1'b1;
		else if (m_tvalid && m_tready)
			busy_q <= 1'b0;
	end

	// beat sideband alongside the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LANE_LAT; k++)
				ctl_pipe_q[k] <= '0;
		end else begin
			ctl_pipe_q[0] <= '{valid: s_beat, last: s_tlast};
			for (int k = 1; k < LANE_LAT; k++)
				ctl_pipe_q[k] <= ctl_pipe_q[k-1];
		end
	end

	// channel lanes
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		wrmse_lane #(
			.CHANNEL_BITS(CHANNEL_BITS)
		) u_lane (
			.clk          (clk),
			.gamma_metric (gamma_q),
			.weight       (weight_q[l]),
			.src          (s_tdata[l*FIELD_W +: CHANNEL_BITS]),
			.rec          (s_tdata[(LANES+l)*FIELD_W +: CHANNEL_BITS]),
			.sq           (lane_sq[l])
		);
	end

	wrmse_merge #(
		.COUNT_BITS(COUNT_BITS)
	) u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl_pipe_q[LANE_LAT-1]),
		.sq      (lane_sq),
		.req     (req),
		.req_sum (req_sum),
		.req_cnt (req_cnt)
	);

	wrmse_div #(
		.COUNT_BITS(COUNT_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_sum   (req_sum),
		.req_cnt   (req_cnt),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.mean      (mean),
		.count     (count),
		.sat       (sat)
	);

	assign m_tdata = {{M_PAD_W{1'b0}}, sat, OUT_CNT_W'(count), mean};

endmodule

`default_nettype wire

### hdl/wrmse_chk.sv
// ============================================================================
// wrmse_chk: port-level checks for the weighted RGB MSE accumulator
// Watches stall behavior around image ends and the result beat.
// ============================================================================
`default_nettype none

module wrmse_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              s_tlast,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [wrmse_pkg::M_DATA_W-1:0]    m_tdata
);
	import wrmse_pkg::*;

	// input closes after a last beat
	a_close_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("input still open after last beat");

	// no pixel taken while a result is waiting
	a_hold_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input open while result pending");

	// input reopens once the result is taken
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready) |=> s_tready)
		else $error("input not reopened after result beat");

	// a result always counts the last pixel
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[MEAN_W +: OUT_CNT_W] != '0))
		else $error("result with zero pixel count");

	// stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result beat changed under stall");

endmodule

bind weighted_rgb_mse_accumulator wrmse_chk u_wrmse_chk (.*);

`default_nettype wire

### bench/mse_result_checker.sv
// ----------------------------------------------------------------------------
// mse_result_checker: result predictor and comparator
// Watches the pixel, result and configuration ports of the weighted RGB MSE
// accumulator. Keeps its own copy of the registers, the running error sum
// and the pixel count. Queues one expected result per last-marked pixel and
// compares each result beat, field by field, against the oldest entry.
// ----------------------------------------------------------------------------
module mse_result_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	input  logic                                  s_tready,
	input  logic [wrmse_pkg::S_DATA_W-1:0]        s_tdata,
	input  logic                                  s_tlast,
	input  logic                                  m_tvalid,
	input  logic                                  m_tready,
	input  logic [wrmse_pkg::M_DATA_W-1:0]        m_tdata,
	input  logic                                  cfg_we,
	input  wrmse_pkg::cfg_idx_t                   cfg_index,
	input  logic [wrmse_pkg::CFG_W-1:0]           cfg_data,
	output int                                    fail_count,
	output int                                    results_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import wrmse_pkg::*;

	localparam logic [63:0] MEAN_CLAMP = 64'h0000_00FF_FFFF_FFFF;

	typedef struct packed {
		logic [MEAN_W-1:0]    mean_error;
		logic [OUT_CNT_W-1:0] pixels_seen;
		logic                 saturated;
	} image_result_t;

	// register copies
	logic                gamma_on;
	logic [WEIGHT_W-1:0] w_red;
	logic [WEIGHT_W-1:0] w_green;
	logic [WEIGHT_W-1:0] w_blue;

	// running image state
	logic [63:0]         err_sum;
	logic [31:0]         pix_count;
	logic                sat_flag;

	logic [WIDE_W-1:0]   srgb_lut [1 << FIELD_W];
	image_result_t       image_results_q [$];

	// Q62 fixed-point product, truncated
	function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] prod;
		prod = 128'(a) * 128'(b);
		return 64'(prod >> 62);
	endfunction

	function automatic logic [63:0] q62_pow12(input logic [63:0] u);
		logic [63:0] u4;
		u4 = q62_mul(q62_mul(u, u), q62_mul(u, u));
		return q62_mul(q62_mul(u4, u4), u4);
	endfunction

	// round(65535 * srgb_encode(i / max)) in fixed point
	function automatic logic [WIDE_W-1:0] srgb_code(input logic [63:0] i);
		logic [63:0]  maxv;
		logic [63:0]  x;
		logic [63:0]  lo;
		logic [63:0]  hi;
		logic [63:0]  mid;
		logic [63:0]  u4;
		logic [63:0]  t32;
		logic [63:0]  num;
		logic [63:0]  sub;
		logic [63:0]  y;
		logic [127:0] x_wide;
		maxv = (64'd1 << FIELD_W) - 64'd1;
		if (i * 64'd10000000 <= 64'd31308 * maxv) begin
			// linear toe, exact rounding
			y = (64'd65535 * 64'd1292 * i + 64'd50 * maxv) / (64'd100 * maxv);
		end else begin
			// u = x^(1/12) by bisection, then x^(5/12) = u^5
			x_wide = (128'(i) << 62) / 128'(maxv);
			x = x_wide[63:0];
			lo = 64'd0;
			hi = 64'd1 << 62;
			while (lo < hi) begin
				mid = lo + ((hi - lo + 64'd1) >> 1);
				if (q62_pow12(mid) <= x)
					lo = mid;
				else
					hi = mid - 64'd1;
			end
			u4 = q62_mul(q62_mul(lo, lo), q62_mul(lo, lo));
			t32 = q62_mul(u4, lo) >> 30;
			num = 64'd65535 * 64'd1055 * t32;
			sub = (64'd65535 * 64'd55) << 32;
			if (num <= sub)
				y = 64'd0;
			else
				y = (num - sub + (64'd500 << 32)) / (64'd1000 << 32);
		end
		return (y > 64'd65535) ? 16'hFFFF : y[WIDE_W-1:0];
	endfunction

	function automatic logic [WIDE_W-1:0] widen_channel(input logic [FIELD_W-1:0] v);
		if (gamma_on)
			return srgb_lut[v];
		return {v, v[FIELD_W-1 -: WIDE_W-FIELD_W]};
	endfunction

	// e = floor(diff * w / 2^14), squared
	function automatic logic [63:0] channel_sq_error(input logic [FIELD_W-1:0] s,
			input logic [FIELD_W-1:0] r, input logic [WEIGHT_W-1:0] w);
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] e;
		a = 64'(widen_channel(s));
		b = 64'(widen_channel(r));
		if (a >= b)
			e = ((a - b) * 64'(w)) >> WEIGHT_FRAC;
		else
			e = ((b - a) * 64'(w) + 64'd16383) >> WEIGHT_FRAC;
		return e * e;
	endfunction

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// fold one accepted pixel beat into the running image state
	task automatic accumulate_pixel();
		logic [63:0]   add;
		logic [63:0]   mean;
		image_result_t res;
		add = channel_sq_error(s_tdata[0 +: FIELD_W], s_tdata[3*FIELD_W +: FIELD_W], w_red)
		    + channel_sq_error(s_tdata[FIELD_W +: FIELD_W], s_tdata[4*FIELD_W +: FIELD_W],
		                       w_green)
		    + channel_sq_error(s_tdata[2*FIELD_W +: FIELD_W], s_tdata[5*FIELD_W +: FIELD_W],
		                       w_blue);
		if (err_sum > ~64'd0 - add) begin
			err_sum = ~64'd0;
			sat_flag = 1'b1;
		end else begin
			err_sum = err_sum + add;
		end
		if (pix_count == '1)
			sat_flag = 1'b1;
		else
			pix_count = pix_count + 32'd1;
		if (s_tlast) begin
			mean = (pix_count != 0) ? err_sum / 64'(pix_count) : 64'd0;
			if (mean > MEAN_CLAMP)
				mean = MEAN_CLAMP;
			res.mean_error = mean[MEAN_W-1:0];
			res.pixels_seen = pix_count;
			res.saturated = sat_flag;
			image_results_q.push_back(res);
			err_sum = '0;
			pix_count = '0;
			sat_flag = 1'b0;
		end
	endtask

	task automatic check_result();
		image_result_t want;
		if (image_results_q.size() == 0) begin
			$error("result beat with no image pending");
			fail_count++;
		end else begin
			want = image_results_q.pop_front();
			compare_field("mean_error", 64'(want.mean_error), 64'(m_tdata[0 +: MEAN_W]));
			compare_field("pixels_seen", 64'(want.pixels_seen),
			              64'(m_tdata[MEAN_W +: OUT_CNT_W]));
			compare_field("saturated", 64'(want.saturated),
			              64'(m_tdata[MEAN_W + OUT_CNT_W]));
		end
	endtask

	// sRGB table, built once
	initial begin
		for (int i = 0; i < (1 << FIELD_W); i++)
			srgb_lut[i] = srgb_code(64'(i));
	end

	// track config, predict on pixel beats, check result beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_on = 1'b0;
			w_red = WEIGHT_ONE;
			w_green = WEIGHT_ONE;
			w_blue = WEIGHT_ONE;
			err_sum = '0;
			pix_count = '0;
			sat_flag = 1'b0;
			image_results_q.delete();
			fail_count = 0;
			results_pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_GAMMA:        gamma_on = cfg_data[0];
					CFG_WEIGHT_RED:   w_red = cfg_data;
					CFG_WEIGHT_GREEN: w_green = cfg_data;
					CFG_WEIGHT_BLUE:  w_blue = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				accumulate_pixel();
			if (m_tvalid && m_tready)
				check_result();
			results_pending <= image_results_q.size();
		end
	end

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: weighted RGB MSE accumulator testbench
// Drives pixel beats, register writes and result back-pressure. A short
// directed run covers extreme channels, negative differences, the sRGB toe
// boundary and zero and full-scale weights; random images follow under nine
// register settings and three idle profiles. The checker does the prediction.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import wrmse_pkg::*;

	// settle() waits this long after the last result has come back
	localparam int DRAIN_CYCLES = 80;
	localparam int PHASE_PIXELS = 72;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// src_red, src_green, src_blue, rec_red, rec_green, rec_blue (12 bits each)
	logic [S_DATA_W-1:0]   s_tdata = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// mean_error (40), pixels_seen (32), saturated (1), zero pad (7)
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  cfg_we = 1'b0;
	cfg_idx_t              cfg_index = CFG_GAMMA;
	logic [CFG_W-1:0]      cfg_data = '0;

	int                    fail_count;
	int                    results_pending;
	int                    send_gap_pct = 9;
	int                    ready_drop_pct = 47;

	weighted_rgb_mse_accumulator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	mse_result_checker mse_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.results_pending (results_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= ready_drop_pct);
	end

	// one pixel beat, with random gaps ahead of it
	task automatic send_pixel(input logic [FIELD_W-1:0] sr, input logic [FIELD_W-1:0] sg,
			input logic [FIELD_W-1:0] sb, input logic [FIELD_W-1:0] rr,
			input logic [FIELD_W-1:0] rg, input logic [FIELD_W-1:0] rb, input logic last);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {rb, rg, rr, sb, sg, sr};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	// hold off until every result is back and the lanes have drained
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic gamma, input logic [WEIGHT_W-1:0] wr,
			input logic [WEIGHT_W-1:0] wg, input logic [WEIGHT_W-1:0] wb);
		cfg_we <= 1'b1;
		cfg_index <= CFG_GAMMA;
		cfg_data <= {{(CFG_W-1){1'b0}}, gamma};
		@(posedge clk);
		cfg_index <= CFG_WEIGHT_RED;
		cfg_data <= wr;
		@(posedge clk);
		cfg_index <= CFG_WEIGHT_GREEN;
		cfg_data <= wg;
		@(posedge clk);
		cfg_index <= CFG_WEIGHT_BLUE;
		cfg_data <= wb;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// random images, mostly short; the last image is cut to fit n_pixels
	task automatic run_random_images(input int n_pixels);
		int                 sent;
		int                 img_len;
		int                 mode;
		int                 v;
		logic [FIELD_W-1:0] src [3];
		logic [FIELD_W-1:0] rec [3];
		sent = 0;
		while (sent < n_pixels) begin
			img_len = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 60)
			                                       : $urandom_range(1, 12);
			if (img_len > n_pixels - sent)
				img_len = n_pixels - sent;
			for (int p = 0; p < img_len; p++) begin
				mode = $urandom_range(0, 9);
				for (int c = 0; c < 3; c++) begin
					src[c] = FIELD_W'($urandom);
					case (mode)
						0, 1, 2, 3: rec[c] = FIELD_W'($urandom);
						4, 5, 6: begin
							// close reconstruction
							v = int'(src[c]) + int'($urandom_range(0, 62)) - 31;
							if (v < 0)
								v = 0;
							if (v > 4095)
								v = 4095;
							rec[c] = FIELD_W'(v);
						end
						7: begin
							src[c] = $urandom_range(0, 1) ? '1 : '0;
							rec[c] = $urandom_range(0, 1) ? '1 : '0;
						end
						8: rec[c] = src[c];
						default: begin
							// dark values around the sRGB linear toe
							src[c] = FIELD_W'($urandom_range(0, 20));
							rec[c] = FIELD_W'($urandom_range(0, 20));
						end
					endcase
				end
				send_pixel(src[0], src[1], src[2], rec[0], rec[1], rec[2],
				           p == img_len - 1);
				sent++;
			end
		end
	endtask

	initial begin
		logic                gam;
		logic [WEIGHT_W-1:0] wv [3];
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: linear widening, unit weights
		send_pixel(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1);
		send_pixel(12'hFFF, 12'hFFF, 12'hFFF, 12'd0, 12'd0, 12'd0, 1'b1);
		send_pixel(12'd0, 12'd0, 12'd0, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1);
		send_pixel(12'd1, 12'd0, 12'd2048, 12'd0, 12'd1, 12'd2047, 1'b0);
		send_pixel(12'd0, 12'd1, 12'd5, 12'd1, 12'd0, 12'd9, 1'b0);
		send_pixel(12'd4095, 12'd4094, 12'd0, 12'd4094, 12'd4095, 12'd1, 1'b1);

		// sRGB on, odd weights: toe boundary and floor of negative errors
		settle();
		set_config(1'b1, 16'd1, 16'hFFFF, 16'd12345);
		send_pixel(12'd12, 12'd13, 12'hFFF, 12'd13, 12'd12, 12'd0, 1'b1);
		send_pixel(12'd0, 12'd1, 12'd4094, 12'd1, 12'd0, 12'hFFF, 1'b0);
		send_pixel(12'd3000, 12'd100, 12'd7, 12'd2999, 12'd101, 12'd8, 1'b1);

		// zero weights
		settle();
		set_config(1'b0, 16'd0, 16'd0, 16'd0);
		send_pixel(12'hFFF, 12'hFFF, 12'hFFF, 12'd0, 12'd0, 12'd0, 1'b1);

		// full-scale weights, largest errors
		settle();
		set_config(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_pixel(12'hFFF, 12'hFFF, 12'hFFF, 12'd0, 12'd0, 12'd0, 1'b0);
		send_pixel(12'd0, 12'd0, 12'd0, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0);
		send_pixel(12'hFFF, 12'd0, 12'hFFF, 12'd0, 12'hFFF, 12'd0, 1'b1);

		// random phases, one register setting each
		for (int phase = 0; phase < 9; phase++) begin
			if (phase == 3) begin
				send_gap_pct = 47;
				ready_drop_pct = 9;
			end else if (phase == 6) begin
				send_gap_pct = 0;
				ready_drop_pct = 0;
			end
			case (phase % 3)
				0: gam = 1'b0;
				1: gam = 1'b1;
				default: gam = 1'($urandom_range(0, 1));
			endcase
			for (int c = 0; c < 3; c++) begin
				case (phase % 4)
					0: wv[c] = 16'hFFFF;
					1: wv[c] = 16'd0;
					2: wv[c] = ($urandom_range(0, 3) == 0) ? WEIGHT_W'($urandom_range(0, 64))
					                                       : WEIGHT_W'($urandom);
					default: wv[c] = WEIGHT_ONE;
				endcase
			end
			settle();
			set_config(gam, wv[0], wv[1], wv[2]);
			run_random_images(PHASE_PIXELS);
		end

		settle();
		if (fail_count == 0 && results_pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
